// ===== sv/vcht_pkg.sv =====
`default_nettype none
package vcht_pkg;

  localparam int KEY_W    = 46;
  localparam int COST_W   = 32;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 12;
  localparam int HASH_W   = 32;

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND        = 3'd0,
    ST_MISS         = 3'd1,
    ST_INSERTED     = 3'd2,
    ST_IMPROVED     = 3'd3,
    ST_NOT_IMPROVED = 3'd4,
    ST_FULL         = 3'd5,
    ST_CLEARED      = 3'd6
  } status_t;

  typedef struct packed {
    logic              used;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  pred;
    logic [COST_W-1:0] cost;
    logic              pred_valid;
  } entry_t;

endpackage
`default_nettype wire

// ===== sv/vcht_if.sv =====
`default_nettype none
interface vcht_req_if;
  logic                        valid;
  logic                        ready;
  logic [vcht_pkg::MODE_W-1:0] mode;
  logic [vcht_pkg::KEY_W-1:0]  node_key;
  logic [vcht_pkg::KEY_W-1:0]  pred_key;
  logic [vcht_pkg::COST_W-1:0] path_cost;
  logic                        pred_valid;

  modport source (output valid, mode, node_key, pred_key, path_cost, pred_valid,
                  input ready);
  modport sink (input valid, mode, node_key, pred_key, path_cost, pred_valid,
                output ready);
endinterface

interface vcht_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [vcht_pkg::STATUS_W-1:0] status;
  logic [vcht_pkg::KEY_W-1:0]    entry_pred_key;
  logic [vcht_pkg::COST_W-1:0]   entry_cost;
  logic                          entry_pred_valid;
  logic [vcht_pkg::SLOT_W-1:0]   entry_slot;

  modport source (output valid, status, entry_pred_key, entry_cost, entry_pred_valid,
                  entry_slot, input ready);
  modport sink (input valid, status, entry_pred_key, entry_cost, entry_pred_valid,
                entry_slot, output ready);
endinterface
`default_nettype wire

// ===== sv/visited_cost_hash_table_unit.sv =====
`default_nettype none
// Visited-node table with linear probing. An operation hashes its key on one
// shared 32x32 multiplier, one round per key field, then hands the slot over;
// when TABLE_DEPTH is not a power of two, a reciprocal modulo reduction on the
// same multiplier follows (quotient estimate, remainder, correction). Each probed
// slot takes a registered table read, then a compare; the result is then loaded
// into the response beat. The table memory is the bottleneck of probing: one slot
// is read per probe. A clear sweeps the whole table, one slot per cycle, then
// loads its beat; the same sweep runs after reset with ready low. The block takes
// one request at a time and holds ready low while busy, but accepts the next
// request while the previous response beat still waits; a finished result then
// waits until that beat is taken.
module visited_cost_hash_table_unit #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input wire logic  clk,
  input wire logic  rst,
  vcht_req_if.sink  req,
  vcht_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_HASH, S_RD, S_CHK, S_DONE} state_t;

  state_t                        state;
  logic [vcht_pkg::MODE_W-1:0]   op_mode;
  logic [vcht_pkg::KEY_W-1:0]    op_key;
  logic [vcht_pkg::KEY_W-1:0]    op_pred;
  logic [vcht_pkg::COST_W-1:0]   op_cost;
  logic                          op_pv;
  logic [IDX_W-1:0]              slot;
  logic [IDX_W-1:0]              probes;
  logic [IDX_W-1:0]              clr_ptr;
  logic                          clr_emit;
  vcht_pkg::status_t             res_status;
  logic [vcht_pkg::KEY_W-1:0]    res_pred;
  logic [vcht_pkg::COST_W-1:0]   res_cost;
  logic                          res_pv;
  logic [IDX_W-1:0]              res_slot;
  logic                          out_valid;
  logic                          load_rsp;

  vcht_pkg::entry_t              mem [TABLE_DEPTH];
  vcht_pkg::entry_t              rdata;
  vcht_pkg::entry_t              wdata;
  logic                          we;
  logic [IDX_W-1:0]              waddr;

  logic                          accept;
  logic                          hash_start;
  logic                          hash_done;
  logic [IDX_W-1:0]              hash_slot;
  logic                          is_ins;
  logic                          key_hit;
  logic                          lower;

  assign req.ready = (state == S_IDLE);
  assign accept = req.valid && req.ready;
  assign hash_start = accept && (req.mode != vcht_pkg::MODE_CLEAR);
  assign load_rsp = (state == S_DONE) && (!out_valid || rsp.ready);

  assign rsp.valid = out_valid;

  vcht_hash #(.TABLE_DEPTH(TABLE_DEPTH)) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (op_key),
    .done  (hash_done),
    .slot  (hash_slot)
  );

  always_comb begin
    is_ins  = (op_mode == vcht_pkg::MODE_INSERT);
    key_hit = rdata.used && (rdata.key == op_key);
    lower   = (op_cost < rdata.cost);
    wdata.used       = 1'b1;
    wdata.key        = op_key;
    wdata.pred       = op_pred;
    wdata.cost       = op_cost;
    wdata.pred_valid = op_pv;
    waddr = slot;
    we    = 1'b0;
    case (state)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_ptr;
        wdata = '0;
      end
      S_CHK: begin
        we = is_ins && (!rdata.used || (key_hit && lower));
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_ptr   <= '0;
      clr_emit  <= 1'b0;
      out_valid <= 1'b0;
      probes    <= '0;
    end else begin
      out_valid <= load_rsp || (out_valid && !rsp.ready);
      case (state)
        S_CLR: begin
          if (clr_ptr == LAST_SLOT) begin
            clr_ptr <= '0;
            if (clr_emit) begin
              res_status <= vcht_pkg::ST_CLEARED;
              res_pred   <= '0;
              res_cost   <= '0;
              res_pv     <= 1'b0;
              res_slot   <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            clr_ptr <= clr_ptr + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_mode <= req.mode;
            op_key  <= req.node_key;
            op_pred <= req.pred_key;
            op_cost <= req.path_cost;
            op_pv   <= req.pred_valid;
            if (req.mode == vcht_pkg::MODE_CLEAR) begin
              clr_ptr  <= '0;
              clr_emit <= 1'b1;
              state    <= S_CLR;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            slot   <= hash_slot;
            probes <= '0;
            state  <= S_RD;
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (!rdata.used) begin
            res_status <= is_ins ? vcht_pkg::ST_INSERTED : vcht_pkg::ST_MISS;
            res_pred   <= is_ins ? op_pred : '0;
            res_cost   <= is_ins ? op_cost : '0;
            res_pv     <= is_ins ? op_pv : 1'b0;
            res_slot   <= is_ins ? slot : '0;
            state      <= S_DONE;
          end else if (key_hit) begin
            res_slot <= slot;
            if (is_ins && lower) begin
              res_status <= vcht_pkg::ST_IMPROVED;
              res_pred   <= op_pred;
              res_cost   <= op_cost;
              res_pv     <= op_pv;
            end else begin
              res_status <= is_ins ? vcht_pkg::ST_NOT_IMPROVED : vcht_pkg::ST_FOUND;
              res_pred   <= rdata.pred;
              res_cost   <= rdata.cost;
              res_pv     <= rdata.pred_valid;
            end
            state <= S_DONE;
          end else if (probes == LAST_SLOT) begin
            res_status <= is_ins ? vcht_pkg::ST_FULL : vcht_pkg::ST_MISS;
            res_pred   <= '0;
            res_cost   <= '0;
            res_pv     <= 1'b0;
            res_slot   <= '0;
            state      <= S_DONE;
          end else begin
            slot   <= (slot == LAST_SLOT) ? '0 : slot + 1'b1;
            probes <= probes + 1'b1;
            state  <= S_RD;
          end
        end
        S_DONE: begin
          if (load_rsp) begin
            rsp.status           <= res_status;
            rsp.entry_pred_key   <= res_pred;
            rsp.entry_cost       <= res_cost;
            rsp.entry_pred_valid <= res_pv;
            rsp.entry_slot       <= vcht_pkg::SLOT_W'(res_slot);
            clr_emit             <= 1'b0;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/vcht_hash.sv =====
`default_nettype none
module vcht_hash #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [vcht_pkg::KEY_W-1:0] key,
  output logic                            done,
  output logic [$clog2(TABLE_DEPTH)-1:0]  slot
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int PROD_W = 2 * vcht_pkg::HASH_W;
  localparam bit IS_POW2 = (TABLE_DEPTH == (1 << IDX_W));
  localparam logic [vcht_pkg::HASH_W-1:0] DEP = vcht_pkg::HASH_W'(TABLE_DEPTH);
  // floor(2^32 / depth), the quotient estimate is low by at most one
  localparam logic [vcht_pkg::HASH_W-1:0] RECIP =
    vcht_pkg::HASH_W'((PROD_W'(1) << vcht_pkg::HASH_W) / TABLE_DEPTH);

  typedef enum logic [2:0] {H_IDLE, H_MUL, H_QUO, H_REM, H_FIX} hstate_t;

  hstate_t                         state;
  logic [1:0]                      rnd;
  logic [vcht_pkg::HASH_W-1:0]     h;
  logic [vcht_pkg::HASH_W-1:0]     quo;
  logic [vcht_pkg::HASH_W-1:0]     rem;
  logic [vcht_pkg::HASH_W-1:0]     field;
  logic [vcht_pkg::HASH_W-1:0]     mix;
  logic [vcht_pkg::HASH_W-1:0]     mul_a;
  logic [vcht_pkg::HASH_W-1:0]     mul_b;
  logic [PROD_W-1:0]               prod;

  // one shared 32x32 multiplier for the hash rounds and the reduction
  always_comb begin
    case (rnd)
      2'd0:    field = {29'd0, key[2:0]};
      2'd1:    field = {10'd0, key[24:3]};
      default: field = {11'd0, key[45:25]};
    endcase
    mix = h ^ field;
    case (state)
      H_QUO: begin
        mul_a = h;
        mul_b = RECIP;
      end
      H_REM: begin
        mul_a = quo;
        mul_b = DEP;
      end
      default: begin
        mul_a = mix;
        mul_b = vcht_pkg::FNV_PRIME;
      end
    endcase
    prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      done  <= 1'b0;
      rnd   <= '0;
    end else begin
      case (state)
        H_IDLE: begin
          done <= 1'b0;
          if (start) begin
            h     <= vcht_pkg::FNV_BASIS;
            rnd   <= '0;
            state <= H_MUL;
          end
        end
        H_MUL: begin
          h    <= prod[vcht_pkg::HASH_W-1:0];
          rnd  <= rnd + 2'd1;
          done <= (rnd == 2'd2) && IS_POW2;
          if (rnd == 2'd2) begin
            if (IS_POW2) begin
              slot  <= IDX_W'(prod[vcht_pkg::HASH_W-1:0]);
              state <= H_IDLE;
            end else begin
              state <= H_QUO;
            end
          end
        end
        H_QUO: begin
          done  <= 1'b0;
          quo   <= prod[PROD_W-1:vcht_pkg::HASH_W];
          state <= H_REM;
        end
        H_REM: begin
          done  <= 1'b0;
          rem   <= h - prod[vcht_pkg::HASH_W-1:0];
          state <= H_FIX;
        end
        H_FIX: begin
          done  <= 1'b1;
          slot  <= (rem >= DEP) ? IDX_W'(rem - DEP) : IDX_W'(rem);
          state <= H_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= H_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int DEPTH        = 4096;
  localparam int LIMIT_CYCLES = 1500000;
  localparam int RANDOM_OPS   = 1530;
  localparam int QUIET_FROM   = 600;
  localparam int QUIET_TO     = 900;
  localparam int TAIL_CYCLES  = 100;

  localparam logic [vcht_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam logic [vcht_pkg::KEY_W-1:0]  KEY_ONES   = '1;
  localparam logic [vcht_pkg::COST_W-1:0] COST_MAX   = '1;

  typedef struct packed {
    logic [vcht_pkg::MODE_W-1:0] mode;
    logic [vcht_pkg::KEY_W-1:0]  node_key;
    logic [vcht_pkg::KEY_W-1:0]  pred_key;
    logic [vcht_pkg::COST_W-1:0] path_cost;
    logic                        pred_valid;
  } table_op_t;

  typedef struct packed {
    vcht_pkg::status_t           status;
    logic [vcht_pkg::KEY_W-1:0]  pred_key;
    logic [vcht_pkg::COST_W-1:0] cost;
    logic                        pred_valid;
    logic [vcht_pkg::SLOT_W-1:0] slot;
  } table_reply_t;

  logic clk = 1'b0;
  logic rst;

  vcht_req_if req_bus ();
  vcht_rsp_if rsp_bus ();

  visited_cost_hash_table_unit #(.TABLE_DEPTH(DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  always #5 clk = ~clk;

  // shadow copy of the visited table
  bit                          shadow_used [DEPTH];
  logic [vcht_pkg::KEY_W-1:0]  shadow_key  [DEPTH];
  logic [vcht_pkg::KEY_W-1:0]  shadow_pred [DEPTH];
  logic [vcht_pkg::COST_W-1:0] shadow_cost [DEPTH];
  logic                        shadow_pv   [DEPTH];

  table_op_t                  ops_to_send [$];
  table_reply_t               replies_due [$];
  logic [vcht_pkg::KEY_W-1:0] known_keys [$];
  logic [vcht_pkg::KEY_W-1:0] cluster_keys [$];

  table_op_t    cur_op;
  table_reply_t new_reply;
  table_reply_t want;
  bit           req_taken;
  int           ops_accepted;
  int           replies_seen;
  int           error_count;
  int           cycle_count;

  function automatic logic [31:0] fnv_of_key(input logic [vcht_pkg::KEY_W-1:0] k);
    logic [31:0] h;
    h = vcht_pkg::FNV_BASIS;
    h = (h ^ {29'd0, k[2:0]}) * vcht_pkg::FNV_PRIME;
    h = (h ^ {10'd0, k[24:3]}) * vcht_pkg::FNV_PRIME;
    h = (h ^ {11'd0, k[45:25]}) * vcht_pkg::FNV_PRIME;
    return h;
  endfunction

  function automatic logic [vcht_pkg::KEY_W-1:0] rand_key();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[vcht_pkg::KEY_W-1:0];
  endfunction

  // random key whose home slot is target: solve the last multiply for the node bits
  function automatic logic [vcht_pkg::KEY_W-1:0] key_for_slot(
      input logic [vcht_pkg::SLOT_W-1:0] target);
    logic [2:0]                  lvl;
    logic [21:0]                 tile;
    logic [20:0]                 node;
    logic [31:0]                 h;
    logic [31:0]                 prime;
    logic [vcht_pkg::SLOT_W-1:0] p12;
    logic [vcht_pkg::SLOT_W-1:0] inv;
    lvl   = 3'($urandom);
    tile  = 22'($urandom);
    node  = 21'($urandom);
    prime = vcht_pkg::FNV_PRIME;
    p12   = prime[vcht_pkg::SLOT_W-1:0];
    inv   = p12;
    repeat (3) inv = inv * (12'd2 - p12 * inv);
    h = (vcht_pkg::FNV_BASIS ^ {29'd0, lvl}) * vcht_pkg::FNV_PRIME;
    h = (h ^ {10'd0, tile}) * vcht_pkg::FNV_PRIME;
    node[vcht_pkg::SLOT_W-1:0] = h[vcht_pkg::SLOT_W-1:0] ^ (target * inv);
    return {node, tile, lvl};
  endfunction

  function automatic logic [vcht_pkg::COST_W-1:0] pick_cost();
    case ($urandom_range(9))
      0: return '0;
      1: return COST_MAX;
      2, 3: return $urandom_range(20);
      4: return $urandom & 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic bit take_break(input int count);
    if (count >= QUIET_FROM && count < QUIET_TO) return 1'b0;
    return $urandom_range(99) < 35;
  endfunction

  task automatic apply_table_op(input table_op_t op, output table_reply_t rep);
    logic [vcht_pkg::SLOT_W-1:0] s;
    logic [31:0]                 h;
    bit                          done;
    rep = '0;
    rep.status = vcht_pkg::ST_MISS;
    if (op.mode == vcht_pkg::MODE_CLEAR) begin
      for (int i = 0; i < DEPTH; i++) shadow_used[i] = 1'b0;
      rep.status = vcht_pkg::ST_CLEARED;
      return;
    end
    h = fnv_of_key(op.node_key);
    s = vcht_pkg::SLOT_W'(h % DEPTH);
    done = 1'b0;
    for (int n = 0; n < DEPTH && !done; n++) begin
      if (!shadow_used[s]) begin
        done = 1'b1;
        if (op.mode == vcht_pkg::MODE_INSERT) begin
          shadow_used[s] = 1'b1;
          shadow_key[s]  = op.node_key;
          shadow_pred[s] = op.pred_key;
          shadow_cost[s] = op.path_cost;
          shadow_pv[s]   = op.pred_valid;
          rep.status = vcht_pkg::ST_INSERTED;
        end
      end else if (shadow_key[s] == op.node_key) begin
        done = 1'b1;
        if (op.mode != vcht_pkg::MODE_INSERT) begin
          rep.status = vcht_pkg::ST_FOUND;
        end else if (op.path_cost < shadow_cost[s]) begin
          shadow_pred[s] = op.pred_key;
          shadow_cost[s] = op.path_cost;
          shadow_pv[s]   = op.pred_valid;
          rep.status = vcht_pkg::ST_IMPROVED;
        end else begin
          rep.status = vcht_pkg::ST_NOT_IMPROVED;
        end
      end else begin
        s = (s == DEPTH - 1) ? '0 : s + 1'b1;
      end
    end
    if (!done) begin
      if (op.mode == vcht_pkg::MODE_INSERT) rep.status = vcht_pkg::ST_FULL;
    end else if (rep.status != vcht_pkg::ST_MISS) begin
      rep.pred_key   = shadow_pred[s];
      rep.cost       = shadow_cost[s];
      rep.pred_valid = shadow_pv[s];
      rep.slot       = s;
    end
  endtask

  task automatic add_op(input logic [vcht_pkg::MODE_W-1:0] mode,
                        input logic [vcht_pkg::KEY_W-1:0] key,
                        input logic [vcht_pkg::KEY_W-1:0] pred,
                        input logic [vcht_pkg::COST_W-1:0] cost,
                        input logic pv);
    table_op_t op;
    op.mode       = mode;
    op.node_key   = key;
    op.pred_key   = pred;
    op.path_cost  = cost;
    op.pred_valid = pv;
    ops_to_send.push_back(op);
  endtask

  task automatic flag_error(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic build_random_ops();
    logic [vcht_pkg::MODE_W-1:0] mode;
    logic [vcht_pkg::KEY_W-1:0]  key;
    int                          sel;
    int                          src;
    for (int i = 0; i < RANDOM_OPS; i++) begin
      sel = $urandom_range(999);
      if (sel < 8) mode = vcht_pkg::MODE_CLEAR;
      else if (sel < 30) mode = MODE_SPARE;
      else if (sel < 480) mode = vcht_pkg::MODE_LOOKUP;
      else mode = vcht_pkg::MODE_INSERT;
      src = $urandom_range(99);
      if (src < 50 && known_keys.size() != 0) begin
        key = known_keys[$urandom_range(known_keys.size() - 1)];
      end else if (src < 75) begin
        key = cluster_keys[$urandom_range(cluster_keys.size() - 1)];
      end else begin
        key = rand_key();
        if (mode == vcht_pkg::MODE_INSERT) begin
          if (known_keys.size() < 400) known_keys.push_back(key);
          else known_keys[$urandom_range(399)] = key;
        end
      end
      add_op(mode, key, rand_key(), pick_cost(), 1'($urandom_range(1)));
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else if (req_bus.valid && !req_taken) begin
      // hold the beat until it is taken
    end else begin
      req_taken = 1'b0;
      if (ops_to_send.size() != 0 && !take_break(ops_accepted)) begin
        cur_op = ops_to_send.pop_front();
        req_bus.valid      <= 1'b1;
        req_bus.mode       <= cur_op.mode;
        req_bus.node_key   <= cur_op.node_key;
        req_bus.pred_key   <= cur_op.pred_key;
        req_bus.path_cost  <= cur_op.path_cost;
        req_bus.pred_valid <= cur_op.pred_valid;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && req_bus.valid && req_bus.ready) begin
      req_taken = 1'b1;
      apply_table_op(cur_op, new_reply);
      replies_due.push_back(new_reply);
      ops_accepted++;
    end
  end

  always @(negedge clk) begin
    if (rst) rsp_bus.ready <= 1'b0;
    else rsp_bus.ready <= !take_break(replies_seen);
  end

  // response monitor
  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (replies_due.size() == 0) begin
        flag_error($sformatf("unexpected beat, status %0d", rsp_bus.status));
      end else begin
        want = replies_due.pop_front();
        if (rsp_bus.status !== want.status)
          flag_error($sformatf("beat %0d status %0d, want %0d",
                               replies_seen, rsp_bus.status, want.status));
        if (rsp_bus.entry_pred_key !== want.pred_key)
          flag_error($sformatf("beat %0d pred key %h, want %h",
                               replies_seen, rsp_bus.entry_pred_key, want.pred_key));
        if (rsp_bus.entry_cost !== want.cost)
          flag_error($sformatf("beat %0d cost %h, want %h",
                               replies_seen, rsp_bus.entry_cost, want.cost));
        if (rsp_bus.entry_pred_valid !== want.pred_valid)
          flag_error($sformatf("beat %0d pred valid %b, want %b",
                               replies_seen, rsp_bus.entry_pred_valid, want.pred_valid));
        if (rsp_bus.entry_slot !== want.slot)
          flag_error($sformatf("beat %0d slot %0d, want %0d",
                               replies_seen, rsp_bus.entry_slot, want.slot));
      end
      replies_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [vcht_pkg::KEY_W-1:0] wrap_a;
    logic [vcht_pkg::KEY_W-1:0] wrap_b;
    logic [vcht_pkg::KEY_W-1:0] wrap_c;
    logic [vcht_pkg::KEY_W-1:0] wrap_d;
    rst                = 1'b1;
    req_bus.valid      = 1'b0;
    req_bus.mode       = vcht_pkg::MODE_LOOKUP;
    req_bus.node_key   = '0;
    req_bus.pred_key   = '0;
    req_bus.path_cost  = '0;
    req_bus.pred_valid = 1'b0;
    rsp_bus.ready      = 1'b0;
    req_taken          = 1'b0;

    // directed: extremes, every mode, equal and higher cost, wrap-around chain
    add_op(vcht_pkg::MODE_LOOKUP, '0, KEY_ONES, COST_MAX, 1'b1);
    add_op(vcht_pkg::MODE_INSERT, '0, '0, '0, 1'b0);
    add_op(vcht_pkg::MODE_INSERT, KEY_ONES, KEY_ONES, COST_MAX, 1'b1);
    add_op(vcht_pkg::MODE_LOOKUP, KEY_ONES, '0, '0, 1'b0);
    add_op(vcht_pkg::MODE_INSERT, KEY_ONES, '0, COST_MAX, 1'b0);
    add_op(vcht_pkg::MODE_INSERT, KEY_ONES, 46'h2AAA_AAAA_AAAA, COST_MAX - 1, 1'b0);
    add_op(vcht_pkg::MODE_INSERT, '0, KEY_ONES, 32'd5, 1'b1);
    add_op(MODE_SPARE, '0, KEY_ONES, COST_MAX, 1'b1);
    wrap_a = key_for_slot(vcht_pkg::SLOT_W'(DEPTH - 1));
    wrap_b = key_for_slot(vcht_pkg::SLOT_W'(DEPTH - 1));
    wrap_c = key_for_slot(vcht_pkg::SLOT_W'(DEPTH - 1));
    wrap_d = key_for_slot(vcht_pkg::SLOT_W'(DEPTH - 1));
    add_op(vcht_pkg::MODE_INSERT, wrap_a, rand_key(), 32'd100, 1'b1);
    add_op(vcht_pkg::MODE_INSERT, wrap_b, rand_key(), 32'd100, 1'b1);
    add_op(vcht_pkg::MODE_INSERT, wrap_c, rand_key(), 32'd100, 1'b0);
    add_op(vcht_pkg::MODE_LOOKUP, wrap_c, '0, '0, 1'b0);
    add_op(vcht_pkg::MODE_LOOKUP, wrap_d, '0, '0, 1'b0);
    add_op(vcht_pkg::MODE_INSERT, wrap_b, rand_key(), 32'd99, 1'b0);
    add_op(MODE_SPARE, wrap_d, rand_key(), '0, 1'b1);
    add_op(vcht_pkg::MODE_CLEAR, rand_key(), rand_key(), $urandom, 1'b1);
    add_op(vcht_pkg::MODE_LOOKUP, KEY_ONES, '0, '0, 1'b0);
    add_op(vcht_pkg::MODE_LOOKUP, wrap_a, '0, '0, 1'b0);
    add_op(vcht_pkg::MODE_INSERT, wrap_a, rand_key(), $urandom, 1'b1);

    // small clusters around the end of the table
    for (int c = 0; c < 8; c++)
      repeat (3) cluster_keys.push_back(key_for_slot(vcht_pkg::SLOT_W'((DEPTH - 4 + c) % DEPTH)));
    build_random_ops();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (ops_to_send.size() != 0 || req_bus.valid || replies_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (replies_due.size() != 0)
      flag_error($sformatf("%0d results never arrived", replies_due.size()));

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/vcht_pkg.sv
sv/vcht_if.sv
sv/vcht_hash.sv
sv/visited_cost_hash_table_unit.sv
bench/tb_top.sv
